/* src/lav_pkg.sv */
package lav_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_W          = 31;
	localparam int WORD_W        = 32;
	localparam int ROOT_W        = 32;
	localparam int RAD_W         = 2 * ROOT_W;
	localparam int COLS          = 4;
	localparam int WPC           = 4;
	localparam logic [1:0] LAST_COL = 2'(COLS - 1);

	typedef logic [WPC-1:0][WORD_W-1:0] col_t;
	typedef col_t [COLS-1:0] mat_t;

endpackage

/* src/lav_isqrt.sv */
module lav_isqrt import lav_pkg::*; #(
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [RAD_W-1:0]  rad,
	input  logic [SW-1:0]     in_side,
	output logic              out_v,
	output logic [ROOT_W-1:0] root,
	output logic [SW-1:0]     out_side
);

	localparam int REM_W = ROOT_W + 3;

	typedef struct packed {
		logic [RAD_W-1:0]  n;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [SW-1:0]     side;
	} sq_st_t;

	logic   v_s  [ROOT_W];
	sq_st_t st_s [ROOT_W];

	// one root bit per stage
	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		logic             cur_v;
		sq_st_t           cur;
		sq_st_t           nxt;
		logic [REM_W-1:0] acc;
		logic [REM_W-1:0] trial;

		if (i == 0) begin : g_head
			assign cur_v = in_v;
			assign cur   = '{n: rad, rem: '0, root: '0, side: in_side};
		end else begin : g_body
			assign cur_v = v_s[i-1];
			assign cur   = st_s[i-1];
		end

		always_comb begin
			acc   = {cur.rem[REM_W-3:0], cur.n[RAD_W-1 -: 2]};
			trial = {1'b0, cur.root, 2'b01};
			nxt   = cur;
			nxt.n = {cur.n[RAD_W-3:0], 2'b00};
			if (acc >= trial) begin
				nxt.rem  = acc - trial;
				nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = acc;
				nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i] <= nxt;
			end
		end
	end

	assign out_v    = v_s[ROOT_W-1];
	assign root     = st_s[ROOT_W-1].root;
	assign out_side = st_s[ROOT_W-1].side;

endmodule

/* src/lav_div.sv */
module lav_div import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int VW        = 32,
	parameter int SW        = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_v,
	input  logic [ROOT_W-1:0]        den,
	input  logic [2:0][VW-1:0]       vec,
	input  logic [SW-1:0]            in_side,
	output logic                     out_v,
	output logic [2:0][FRAC_BITS+1:0] unit,
	output logic [SW-1:0]            out_side
);

	localparam int QW    = FRAC_BITS + 1;
	localparam int NW    = FRAC_BITS + 2;
	localparam int RW    = ROOT_W + 2;
	localparam int STEPS = QW;

	typedef struct packed {
		logic [ROOT_W-1:0]  den;
		logic [2:0][RW-1:0] rem;
		logic [2:0][QW-1:0] q;
		logic [2:0]         neg;
		logic [SW-1:0]      side;
	} dv_st_t;

	logic   v_s  [STEPS];
	dv_st_t st_s [STEPS];

	logic [2:0][VW-1:0] mag;
	logic [2:0]         sgn;

	logic                fin_v_s;
	logic [2:0][NW-1:0]  unit_s;
	logic [SW-1:0]       side_s;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sgn[k] = vec[k][VW-1];
			mag[k] = sgn[k] ? (~vec[k] + 1'b1) : vec[k];
		end
	end

	// restoring division, three lanes in lockstep, one quotient bit per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic   cur_v;
		dv_st_t cur;
		dv_st_t nxt;

		if (i == 0) begin : g_head
			assign cur_v = in_v;
			assign cur   = '{den: den,
				rem: {RW'(mag[2]), RW'(mag[1]), RW'(mag[0])},
				q: '0, neg: sgn, side: in_side};
		end else begin : g_body
			assign cur_v = v_s[i-1];
			assign cur   = st_s[i-1];
		end

		always_comb begin
			logic [RW-1:0] acc;
			nxt = cur;
			for (int k = 0; k < 3; k++) begin
				acc = (i == 0) ? cur.rem[k] : {cur.rem[k][RW-2:0], 1'b0};
				if (acc >= RW'(cur.den)) begin
					nxt.rem[k] = acc - RW'(cur.den);
					nxt.q[k]   = {cur.q[k][QW-2:0], 1'b1};
				end else begin
					nxt.rem[k] = acc;
					nxt.q[k]   = {cur.q[k][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i] <= nxt;
			end
		end
	end

	// sign back on, truncation toward zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s <= 1'b0;
		end else if (en) begin
			fin_v_s <= v_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [NW-1:0] mq;
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mq        = {1'b0, st_s[STEPS-1].q[k]};
				unit_s[k] <= st_s[STEPS-1].neg[k] ? (~mq + 1'b1) : mq;
			end
			side_s <= st_s[STEPS-1].side;
		end
	end

	assign out_v    = fin_v_s;
	assign unit     = unit_s;
	assign out_side = side_s;

endmodule

/* src/lav_norm.sv */
module lav_norm import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int VW        = 32,
	parameter int SW        = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  logic [2:0][VW-1:0]        vec,
	input  logic [SW-1:0]             in_side,
	output logic                      out_v,
	output logic [2:0][FRAC_BITS+1:0] unit,
	output logic                      zero,
	output logic [SW-1:0]             out_side
);

	typedef struct packed {
		logic [2:0][VW-1:0] vec;
		logic [SW-1:0]      side;
	} rt_side_t;

	typedef struct packed {
		logic          zero;
		logic [SW-1:0] side;
	} dv_side_t;

	logic                  v_s1;
	logic                  v_s2;
	logic [2:0][RAD_W-1:0] sq_s1;
	logic [2:0][VW-1:0]    vec_s1;
	logic [2:0][VW-1:0]    vec_s2;
	logic [SW-1:0]         side_s1;
	logic [SW-1:0]         side_s2;
	logic [RAD_W-1:0]      rad_s2;
	logic [2:0][RAD_W-1:0] sq;
	rt_side_t              rt_in;
	rt_side_t              rt_out;
	dv_side_t              dv_in;
	dv_side_t              dv_out;
	logic                  rt_v;
	logic [ROOT_W-1:0]     root;

	always_comb begin
		logic [VW-1:0]   mag;
		logic [2*VW-1:0] prod;
		for (int k = 0; k < 3; k++) begin
			mag   = vec[k][VW-1] ? (~vec[k] + 1'b1) : vec[k];
			prod  = mag * mag;
			sq[k] = prod[RAD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1   <= sq;
			vec_s1  <= vec;
			side_s1 <= in_side;
			rad_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			vec_s2  <= vec_s1;
			side_s2 <= side_s1;
		end
	end

	assign rt_in = '{vec: vec_s2, side: side_s2};

	lav_isqrt #(
		.SW($bits(rt_side_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s2),
		.rad      (rad_s2),
		.in_side  (rt_in),
		.out_v    (rt_v),
		.root     (root),
		.out_side (rt_out)
	);

	assign dv_in = '{zero: (root == '0), side: rt_out.side};

	lav_div #(
		.FRAC_BITS (FRAC_BITS),
		.VW        (VW),
		.SW        ($bits(dv_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (rt_v),
		.den      (root),
		.vec      (rt_out.vec),
		.in_side  (dv_in),
		.out_v    (out_v),
		.unit     (unit),
		.out_side (dv_out)
	);

	assign zero     = dv_out.zero;
	assign out_side = dv_out.side;

endmodule

/* src/lav_cross.sv */
module lav_cross import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int AW        = FRAC_BITS_DEF + 2,
	parameter int BW        = IN_W,
	parameter int SW        = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  logic [2:0][AW-1:0]   a,
	input  logic [2:0][BW-1:0]   b,
	input  logic [SW-1:0]        in_side,
	output logic                 out_v,
	output logic [2:0][BW+1:0]   res,
	output logic [SW-1:0]        out_side
);

	localparam int PW = BW + 1;
	localparam int OW = BW + 2;

	logic               v_s1;
	logic               v_s2;
	logic [5:0][PW-1:0] pr_s1;
	logic [2:0][OW-1:0] res_s2;
	logic [SW-1:0]      side_s1;
	logic [SW-1:0]      side_s2;

	function automatic logic [PW-1:0] fmul(input logic [AW-1:0] x, input logic [BW-1:0] y);
		logic signed [AW+BW-1:0] full;
		full = $signed(x) * $signed(y);
		return PW'(full >>> FRAC_BITS);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1[0] <= fmul(a[1], b[2]);
			pr_s1[1] <= fmul(a[2], b[1]);
			pr_s1[2] <= fmul(a[2], b[0]);
			pr_s1[3] <= fmul(a[0], b[2]);
			pr_s1[4] <= fmul(a[0], b[1]);
			pr_s1[5] <= fmul(a[1], b[0]);
			side_s1  <= in_side;
			for (int k = 0; k < 3; k++) begin
				res_s2[k] <= {pr_s1[2*k][PW-1], pr_s1[2*k]}
					- {pr_s1[2*k+1][PW-1], pr_s1[2*k+1]};
			end
			side_s2 <= side_s1;
		end
	end

	assign out_v    = v_s2;
	assign res      = res_s2;
	assign out_side = side_s2;

endmodule

/* src/lav_dot.sv */
module lav_dot import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int CW        = FRAC_BITS_DEF + 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  logic [2:0][FRAC_BITS+1:0] rgt,
	input  logic [2:0][CW-1:0]        cup,
	input  logic [2:0][FRAC_BITS+1:0] fwd,
	input  logic [2:0][IN_W-1:0]      eye,
	input  logic                      degen,
	output logic                      out_v,
	output mat_t                      mat,
	output logic                      out_degen
);

	localparam int NW   = FRAC_BITS + 2;
	localparam int PW   = IN_W + 2;
	localparam int SUMW = PW + 2;

	logic                    v_s1;
	logic                    v_s2;
	logic                    v_s3;
	logic [2:0][2:0][PW-1:0] pr_s1;
	logic [2:0][NW-1:0]      rgt_s1;
	logic [2:0][NW-1:0]      rgt_s2;
	logic [2:0][CW-1:0]      cup_s1;
	logic [2:0][CW-1:0]      cup_s2;
	logic [2:0][NW-1:0]      fwd_s1;
	logic [2:0][NW-1:0]      fwd_s2;
	logic                    degen_s1;
	logic                    degen_s2;
	logic                    degen_s3;
	logic [2:0][SUMW-1:0]    dot_s2;
	mat_t                    mat_n;
	mat_t                    mat_s3;

	function automatic logic [PW-1:0] fmul(input logic [CW-1:0] x, input logic [IN_W-1:0] y);
		logic signed [CW+IN_W-1:0] full;
		full = $signed(x) * $signed(y);
		return PW'(full >>> FRAC_BITS);
	endfunction

	function automatic logic [SUMW-1:0] sx(input logic [PW-1:0] p);
		return {{(SUMW-PW){p[PW-1]}}, p};
	endfunction

	function automatic logic [WORD_W-1:0] sat(input logic [SUMW-1:0] v);
		logic [SUMW-WORD_W:0] hi;
		hi = v[SUMW-1:WORD_W-1];
		if (hi == '0 || &hi) begin
			return v[WORD_W-1:0];
		end else if (v[SUMW-1]) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pr_s1[0][k] <= fmul(CW'($signed(rgt[k])), eye[k]);
				pr_s1[1][k] <= fmul(cup[k], eye[k]);
				pr_s1[2][k] <= fmul(CW'($signed(fwd[k])), eye[k]);
			end
			rgt_s1   <= rgt;
			cup_s1   <= cup;
			fwd_s1   <= fwd;
			degen_s1 <= degen;

			dot_s2[0] <= -(sx(pr_s1[0][0]) + sx(pr_s1[0][1]) + sx(pr_s1[0][2]));
			dot_s2[1] <= -(sx(pr_s1[1][0]) + sx(pr_s1[1][1]) + sx(pr_s1[1][2]));
			dot_s2[2] <= sx(pr_s1[2][0]) + sx(pr_s1[2][1]) + sx(pr_s1[2][2]);
			rgt_s2    <= rgt_s1;
			cup_s2    <= cup_s1;
			fwd_s2    <= fwd_s1;
			degen_s2  <= degen_s1;

			mat_s3   <= mat_n;
			degen_s3 <= degen_s2;
		end
	end

	always_comb begin
		mat_n = '0;
		if (!degen_s2) begin
			for (int k = 0; k < 3; k++) begin
				mat_n[k][0] = WORD_W'($signed(rgt_s2[k]));
				mat_n[k][1] = WORD_W'($signed(cup_s2[k]));
				mat_n[k][2] = -WORD_W'($signed(fwd_s2[k]));
				mat_n[k][3] = '0;
			end
			mat_n[COLS-1][0] = sat(dot_s2[0]);
			mat_n[COLS-1][1] = sat(dot_s2[1]);
			mat_n[COLS-1][2] = sat(dot_s2[2]);
			mat_n[COLS-1][3] = WORD_W'(1) << FRAC_BITS;
		end
	end

	assign out_v     = v_s3;
	assign mat       = mat_s3;
	assign out_degen = degen_s3;

endmodule

/* src/lav_ser.sv */
module lav_ser import lav_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  mat_t              mat,
	input  logic              degen,
	output logic              free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        column_index,
	output logic [WORD_W-1:0] word_a,
	output logic [WORD_W-1:0] word_b,
	output logic [WORD_W-1:0] word_c,
	output logic [WORD_W-1:0] word_d,
	output logic              degenerate,
	output logic              last
);

	logic       busy_q;
	logic [1:0] cnt_q;
	mat_t       cols_q;
	logic       degen_q;
	logic       take;
	logic       load;

	assign take = busy_q && !out_stall;
	assign free = !busy_q || (take && cnt_q == LAST_COL);
	assign load = in_v && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (take) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == LAST_COL) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cols_q  <= mat;
			degen_q <= degen;
		end else if (take) begin
			cols_q[COLS-2:0] <= cols_q[COLS-1:1];
		end
	end

	assign out_valid    = busy_q;
	assign column_index = cnt_q;
	assign word_a       = cols_q[0][0];
	assign word_b       = cols_q[0][1];
	assign word_c       = cols_q[0][2];
	assign word_d       = cols_q[0][3];
	assign degenerate   = degen_q;
	assign last         = (cnt_q == LAST_COL);

endmodule

/* src/look_at_view_matrix.sv */
// Right-handed look-at view matrix, signed fixed point with FRAC_BITS fraction bits.
// Input channel (in_valid/in_stall): one camera setup per transaction, eye, target
// and up vectors of 31-bit signed values.
// Output channel (out_valid/out_stall): four transactions per setup, one per
// column-major group of four matrix words, column_index 0..3, last set on the fourth.
// degenerate marks a zero-length forward or right vector; all words are then zero.
// The pipeline depth lies mostly in the two normalizers, each a 32-stage square
// root followed by a divider of FRAC_BITS+1 quotient stages and a sign register.
// The pipeline takes one setup per cycle while in_stall is low; the output port
// drains each result as four transactions of four words, and new setups can
// still enter while the previous result is being drained.
// The whole pipeline holds when its last stage is full and the output register
// has not finished the previous matrix; in_stall rises then, nothing is dropped.
// Reset clears all valid bits and the serializer's busy flag and column count; the block is ready at once.
module look_at_view_matrix import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [IN_W-1:0]   eye_x,
	input  logic signed [IN_W-1:0]   eye_y,
	input  logic signed [IN_W-1:0]   eye_z,
	input  logic signed [IN_W-1:0]   target_x,
	input  logic signed [IN_W-1:0]   target_y,
	input  logic signed [IN_W-1:0]   target_z,
	input  logic signed [IN_W-1:0]   up_x,
	input  logic signed [IN_W-1:0]   up_y,
	input  logic signed [IN_W-1:0]   up_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               column_index,
	output logic signed [WORD_W-1:0] word_a,
	output logic signed [WORD_W-1:0] word_b,
	output logic signed [WORD_W-1:0] word_c,
	output logic signed [WORD_W-1:0] word_d,
	output logic                     degenerate,
	output logic                     last
);

	localparam int NW = FRAC_BITS + 2;
	localparam int FW = IN_W + 1;
	localparam int RW = IN_W + 2;
	localparam int CW = NW + 2;

	typedef logic [2:0][IN_W-1:0] ivec_t;
	typedef logic [2:0][NW-1:0]   nvec_t;

	typedef struct packed {
		ivec_t eye;
		ivec_t up;
	} side_a_t;

	typedef struct packed {
		ivec_t eye;
		nvec_t fwd;
		logic  zero;
	} side_b_t;

	typedef struct packed {
		ivec_t eye;
		nvec_t fwd;
		nvec_t rgt;
		logic  degen;
	} side_c_t;

	logic               en;
	logic               ser_free;
	logic               v_s1;
	logic [2:0][FW-1:0] fwd_s1;
	side_a_t            sa_s1;
	logic               fn_v;
	nvec_t              fwdn;
	logic               fzero;
	side_a_t            sa_n;
	side_b_t            sb_in;
	logic               cf_v;
	logic [2:0][RW-1:0] rgt;
	side_b_t            sb_c;
	logic               rn_v;
	nvec_t              rgtn;
	logic               rzero;
	side_b_t            sb_n;
	side_c_t            sc_in;
	logic               cu_v;
	logic [2:0][CW-1:0] cup;
	side_c_t            sc_c;
	logic               last_v;
	mat_t               mat;
	logic               mat_degen;

	assign en       = ser_free || !last_v;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_s1[0] <= {target_x[IN_W-1], target_x} - {eye_x[IN_W-1], eye_x};
			fwd_s1[1] <= {target_y[IN_W-1], target_y} - {eye_y[IN_W-1], eye_y};
			fwd_s1[2] <= {target_z[IN_W-1], target_z} - {eye_z[IN_W-1], eye_z};
			sa_s1.eye <= {eye_z, eye_y, eye_x};
			sa_s1.up  <= {up_z, up_y, up_x};
		end
	end

	lav_norm #(
		.FRAC_BITS (FRAC_BITS),
		.VW        (FW),
		.SW        ($bits(side_a_t))
	) u_norm_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s1),
		.vec      (fwd_s1),
		.in_side  (sa_s1),
		.out_v    (fn_v),
		.unit     (fwdn),
		.zero     (fzero),
		.out_side (sa_n)
	);

	assign sb_in = '{eye: sa_n.eye, fwd: fwdn, zero: fzero};

	lav_cross #(
		.FRAC_BITS (FRAC_BITS),
		.AW        (NW),
		.BW        (IN_W),
		.SW        ($bits(side_b_t))
	) u_cross_rgt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (fn_v),
		.a        (fwdn),
		.b        (sa_n.up),
		.in_side  (sb_in),
		.out_v    (cf_v),
		.res      (rgt),
		.out_side (sb_c)
	);

	lav_norm #(
		.FRAC_BITS (FRAC_BITS),
		.VW        (RW),
		.SW        ($bits(side_b_t))
	) u_norm_rgt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (cf_v),
		.vec      (rgt),
		.in_side  (sb_c),
		.out_v    (rn_v),
		.unit     (rgtn),
		.zero     (rzero),
		.out_side (sb_n)
	);

	assign sc_in = '{eye: sb_n.eye, fwd: sb_n.fwd, rgt: rgtn, degen: sb_n.zero || rzero};

	lav_cross #(
		.FRAC_BITS (FRAC_BITS),
		.AW        (NW),
		.BW        (NW),
		.SW        ($bits(side_c_t))
	) u_cross_up (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (rn_v),
		.a        (rgtn),
		.b        (sb_n.fwd),
		.in_side  (sc_in),
		.out_v    (cu_v),
		.res      (cup),
		.out_side (sc_c)
	);

	lav_dot #(
		.FRAC_BITS (FRAC_BITS),
		.CW        (CW)
	) u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_v      (cu_v),
		.rgt       (sc_c.rgt),
		.cup       (cup),
		.fwd       (sc_c.fwd),
		.eye       (sc_c.eye),
		.degen     (sc_c.degen),
		.out_v     (last_v),
		.mat       (mat),
		.out_degen (mat_degen)
	);

	lav_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_v         (last_v),
		.mat          (mat),
		.degen        (mat_degen),
		.free         (ser_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.column_index (column_index),
		.word_a       (word_a),
		.word_b       (word_b),
		.word_c       (word_c),
		.word_d       (word_d),
		.degenerate   (degenerate),
		.last         (last)
	);

endmodule
